### rtl/bsb_pkg.sv
package bsb_pkg;

    localparam int CANVAS_SIDE      = 256;
    localparam int COORD_W          = 8;
    localparam int ADDR_W           = 2 * COORD_W;
    localparam int BRUSH_RADIUS_MAX = 25;
    localparam int OFF_W            = 7;
    localparam int PIX_W            = 10;
    localparam int D2_W             = 11;
    localparam int RQ_W             = 17;
    localparam int RQ2_W            = 2 * RQ_W;
    localparam int SQ_W             = 43;
    localparam int DQ_W             = 22;
    localparam int Q_W              = 17;
    localparam int SCALE_W          = 40;
    localparam int CNT_W            = 5;

    localparam logic [RQ_W-1:0] RQ_MIN   = RQ_W'(4096);
    localparam logic [RQ_W-1:0] RQ_MAX   = RQ_W'(BRUSH_RADIUS_MAX * 4096);
    localparam logic [15:0]     FSAT_MAX = 16'd40960;
    localparam logic [16:0]     WT_ONE   = 17'h10000;

    localparam logic [OFF_W-1:0] OFF_FIRST = OFF_W'(-BRUSH_RADIUS_MAX);
    localparam logic [OFF_W-1:0] OFF_LAST  = OFF_W'(BRUSH_RADIUS_MAX - 1);

    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(21);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(16);
    localparam logic [CNT_W-1:0] CH_LAST   = CNT_W'(2);

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_STAMP = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [2:0] CFG_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_INK     = 3'd2;
    localparam logic [2:0] CFG_SIZE    = 3'd3;
    localparam logic [2:0] CFG_FLOOR   = 3'd4;
    localparam logic [2:0] CFG_CEILING = 3'd5;

    typedef struct packed {
        logic       load_item;
        logic       exec_write;
        logic       exec_read;
        logic       read_capture;
        logic       prep1;
        logic       prep2;
        logic       test;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       mul1;
        logic       mul2;
        logic       wt;
        logic       blend;
        logic [1:0] blend_ch;
        logic       wr_stamp;
        logic       next_off;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic [1:0] act;
        logic       hit;
        logic       off_last;
    } stat_t;

endpackage

### rtl/bsb_datapath.sv
module bsb_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [8:0]        cfg_data,
    input  logic [1:0]        in_action,
    input  logic [7:0]        in_column,
    input  logic [7:0]        in_row,
    input  logic [7:0]        in_red,
    input  logic [7:0]        in_green,
    input  logic [7:0]        in_blue,
    input  logic [15:0]       in_force_req,
    input  logic [15:0]       in_time_step,
    input  bsb_pkg::cmd_t     cmd,
    output bsb_pkg::stat_t    stat,
    output logic [23:0]       out_rgb,
    output logic              out_status
);

    logic [8:0]  cw_reg, ch_reg;
    logic [7:0]  ink_reg, size_reg, floor_reg, ceil_reg;
    logic [8:0]  w_eff, h_eff;

    logic [1:0]  act_reg;
    logic [7:0]  col_reg, row_reg, pr_reg, pg_reg, pb_reg;
    logic [15:0] force_reg, dt_reg;

    logic signed [bsb_pkg::OFF_W-1:0] dx_reg, dy_reg;
    logic signed [bsb_pkg::PIX_W-1:0] px, py;
    logic signed [13:0] dxs, dys;
    logic [bsb_pkg::D2_W-1:0] d2;
    logic on_canvas, in_brush, item_in;
    logic [bsb_pkg::ADDR_W-1:0] stamp_addr, item_addr;

    logic [bsb_pkg::RQ_W-1:0]    rq_reg;
    logic [bsb_pkg::RQ2_W-1:0]   rq2_reg;
    logic [23:0]                 rq_prod, p1_reg;
    logic [15:0]                 fsat;
    logic [bsb_pkg::SCALE_W-1:0] scale_reg;

    logic [bsb_pkg::SQ_W-1:0] sq_v_reg, sq_res_reg, sq_bit_reg, sq_sum;
    logic [bsb_pkg::DQ_W-1:0] dq;
    logic [17:0] rem_reg, rem_t;
    logic [16:0] nlo_reg;
    logic [bsb_pkg::Q_W-1:0] q_reg;
    logic [16:0] fall;
    logic [36:0] pl_reg, ph_reg;
    logic [56:0] total;
    logic [28:0] wt_raw;
    logic [16:0] wt_reg;

    logic [7:0]  old_c, paint_c, blend_c;
    logic signed [8:0]  diff;
    logic signed [26:0] prod;
    logic signed [11:0] vsum;
    logic [8:0]  vv;
    logic [7:0]  nr_reg, ng_reg, nb_reg;

    logic [23:0] mem [0:(1 << bsb_pkg::ADDR_W) - 1];
    logic [23:0] mem_q_reg;
    logic        mem_we, mem_re;
    logic [bsb_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [23:0] mem_wdata;

    logic [23:0] res_rgb_reg, out_rgb_reg;
    logic        res_status_reg, out_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg    <= 9'd256;
            ch_reg    <= 9'd256;
            ink_reg   <= 8'd30;
            size_reg  <= 8'd10;
            floor_reg <= 8'd130;
            ceil_reg  <= 8'd254;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bsb_pkg::CFG_WIDTH:   cw_reg    <= cfg_data;
                bsb_pkg::CFG_HEIGHT:  ch_reg    <= cfg_data;
                bsb_pkg::CFG_INK:     ink_reg   <= cfg_data[7:0];
                bsb_pkg::CFG_SIZE:    size_reg  <= cfg_data[7:0];
                bsb_pkg::CFG_FLOOR:   floor_reg <= cfg_data[7:0];
                bsb_pkg::CFG_CEILING: ceil_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign w_eff = (cw_reg > 9'(bsb_pkg::CANVAS_SIDE)) ? 9'(bsb_pkg::CANVAS_SIDE) : cw_reg;
    assign h_eff = (ch_reg > 9'(bsb_pkg::CANVAS_SIDE)) ? 9'(bsb_pkg::CANVAS_SIDE) : ch_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            act_reg   <= in_action;
            col_reg   <= in_column;
            row_reg   <= in_row;
            pr_reg    <= in_red;
            pg_reg    <= in_green;
            pb_reg    <= in_blue;
            force_reg <= in_force_req;
            dt_reg    <= in_time_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            dx_reg <= bsb_pkg::OFF_FIRST;
            dy_reg <= bsb_pkg::OFF_FIRST;
        end else if (cmd.next_off) begin
            if (dy_reg == bsb_pkg::OFF_LAST) begin
                dy_reg <= bsb_pkg::OFF_FIRST;
                dx_reg <= dx_reg + 1'b1;
            end else begin
                dy_reg <= dy_reg + 1'b1;
            end
        end
    end

    assign px = $signed({2'b00, col_reg}) + $signed({{3{dx_reg[6]}}, dx_reg});
    assign py = $signed({2'b00, row_reg}) + $signed({{3{dy_reg[6]}}, dy_reg});
    assign on_canvas = !px[9] && !py[9] && (px < $signed({1'b0, w_eff}))
                       && (py < $signed({1'b0, h_eff}));
    assign dxs = dx_reg * dx_reg;
    assign dys = dy_reg * dy_reg;
    assign d2 = dxs[10:0] + dys[10:0];
    assign in_brush = {d2, 24'b0} <= {1'b0, rq2_reg};
    assign stamp_addr = {py[7:0], px[7:0]};
    assign item_addr = {row_reg, col_reg};
    assign item_in = ({1'b0, col_reg} < w_eff) && ({1'b0, row_reg} < h_eff);

    assign stat.act = act_reg;
    assign stat.hit = in_brush && on_canvas;
    assign stat.off_last = (dx_reg == bsb_pkg::OFF_LAST) && (dy_reg == bsb_pkg::OFF_LAST);

    assign rq_prod = size_reg * force_reg;
    assign fsat = (force_reg > bsb_pkg::FSAT_MAX) ? bsb_pkg::FSAT_MAX : force_reg;

    always_ff @(posedge aclk) begin
        if (cmd.prep1) begin
            if (rq_prod < 24'(bsb_pkg::RQ_MIN)) begin
                rq_reg <= bsb_pkg::RQ_MIN;
            end else if (rq_prod > 24'(bsb_pkg::RQ_MAX)) begin
                rq_reg <= bsb_pkg::RQ_MAX;
            end else begin
                rq_reg <= rq_prod[bsb_pkg::RQ_W-1:0];
            end
            p1_reg <= ink_reg * dt_reg;
        end
        if (cmd.prep2) begin
            scale_reg <= p1_reg * fsat;
            rq2_reg   <= rq_reg * rq_reg;
        end
    end

    assign sq_sum = sq_res_reg + sq_bit_reg;

    always_ff @(posedge aclk) begin
        if (cmd.test) begin
            sq_v_reg   <= {d2, 32'b0};
            sq_res_reg <= '0;
            sq_bit_reg <= bsb_pkg::SQ_W'(1) << (bsb_pkg::SQ_W - 1);
        end else if (cmd.sqrt_step) begin
            if (sq_v_reg >= sq_sum) begin
                sq_v_reg   <= sq_v_reg - sq_sum;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end else begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
    end

    assign dq = sq_res_reg[bsb_pkg::DQ_W-1:0];
    assign rem_t = {rem_reg[16:0], nlo_reg[16]};

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= {1'b0, dq[21:5]};
            nlo_reg <= {dq[4:0], 12'b0};
            q_reg   <= '0;
        end else if (cmd.div_step) begin
            if (rem_t >= {1'b0, rq_reg}) begin
                rem_reg <= rem_t - {1'b0, rq_reg};
                q_reg   <= {q_reg[15:0], 1'b1};
            end else begin
                rem_reg <= rem_t;
                q_reg   <= {q_reg[15:0], 1'b0};
            end
            nlo_reg <= {nlo_reg[15:0], 1'b0};
        end
    end

    assign fall = q_reg[16] ? 17'd0 : (bsb_pkg::WT_ONE - q_reg);
    assign total = {ph_reg, 20'b0} + {20'b0, pl_reg};
    assign wt_raw = total[56:28];

    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            pl_reg <= scale_reg[19:0] * fall;
        end
        if (cmd.mul2) begin
            ph_reg <= scale_reg[39:20] * fall;
        end
        if (cmd.wt) begin
            wt_reg <= (wt_raw > 29'(bsb_pkg::WT_ONE)) ? bsb_pkg::WT_ONE : wt_raw[16:0];
        end
    end

    always_comb begin
        unique case (cmd.blend_ch)
            2'd0: begin
                old_c   = mem_q_reg[23:16];
                paint_c = pr_reg;
            end
            2'd1: begin
                old_c   = mem_q_reg[15:8];
                paint_c = pg_reg;
            end
            default: begin
                old_c   = mem_q_reg[7:0];
                paint_c = pb_reg;
            end
        endcase
    end

    assign diff = $signed({1'b0, paint_c}) - $signed({1'b0, old_c});
    assign prod = $signed({1'b0, wt_reg}) * diff;
    assign vsum = $signed({4'b0, old_c}) + $signed({prod[26], prod[26:16]});
    assign vv = vsum[8:0];

    always_comb begin
        if (vv < {1'b0, floor_reg}) begin
            blend_c = floor_reg;
        end else if (vv > {1'b0, ceil_reg}) begin
            blend_c = ceil_reg;
        end else begin
            blend_c = vv[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.blend) begin
            unique case (cmd.blend_ch)
                2'd0:    nr_reg <= blend_c;
                2'd1:    ng_reg <= blend_c;
                default: nb_reg <= blend_c;
            endcase
        end
    end

    assign mem_we    = cmd.wr_stamp || (cmd.exec_write && item_in);
    assign mem_waddr = cmd.wr_stamp ? stamp_addr : item_addr;
    assign mem_wdata = cmd.wr_stamp ? {nr_reg, ng_reg, nb_reg} : {pr_reg, pg_reg, pb_reg};
    assign mem_re    = cmd.test || (cmd.exec_read && item_in);
    assign mem_raddr = cmd.test ? stamp_addr : item_addr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            res_rgb_reg    <= '0;
            res_status_reg <= 1'b0;
        end else begin
            if (cmd.exec_write || cmd.exec_read) begin
                res_status_reg <= !item_in;
            end
            if (cmd.read_capture && !res_status_reg) begin
                res_rgb_reg <= mem_q_reg;
            end
        end
        if (cmd.load_out) begin
            out_rgb_reg    <= res_rgb_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_rgb    = {out_rgb_reg[7:0], out_rgb_reg[15:8], out_rgb_reg[23:16]};
    assign out_status = out_status_reg;

endmodule

### rtl/bsb_ctrl.sv
module bsb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  bsb_pkg::stat_t    stat,
    output bsb_pkg::cmd_t     cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_PREP2 = 4'd3;
    localparam logic [3:0] S_TEST  = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_DIVI  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_MUL1  = 4'd8;
    localparam logic [3:0] S_MUL2  = 4'd9;
    localparam logic [3:0] S_WT    = 4'd10;
    localparam logic [3:0] S_BLEND = 4'd11;
    localparam logic [3:0] S_WR    = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0]               state_reg, state_next;
    logic [bsb_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        cmd.blend_ch = cnt_reg[1:0];
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                priority if (stat.act == bsb_pkg::ACT_WRITE) begin
                    cmd.exec_write = 1'b1;
                    state_next     = S_DONE;
                end else if (stat.act == bsb_pkg::ACT_READ) begin
                    cmd.exec_read = 1'b1;
                    state_next    = S_RD;
                end else if (stat.act == bsb_pkg::ACT_STAMP) begin
                    cmd.prep1  = 1'b1;
                    state_next = S_PREP2;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_RD: begin
                cmd.read_capture = 1'b1;
                state_next       = S_DONE;
            end
            S_PREP2: begin
                cmd.prep2  = 1'b1;
                state_next = S_TEST;
            end
            S_TEST: begin
                cmd.test = 1'b1;
                cnt_next = '0;
                if (stat.hit) begin
                    state_next = S_SQRT;
                end else if (stat.off_last) begin
                    state_next = S_DONE;
                end else begin
                    cmd.next_off = 1'b1;
                end
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == bsb_pkg::SQRT_LAST) begin
                    state_next = S_DIVI;
                end
            end
            S_DIVI: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == bsb_pkg::DIV_LAST) begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = S_WT;
            end
            S_WT: begin
                cmd.wt     = 1'b1;
                cnt_next   = '0;
                state_next = S_BLEND;
            end
            S_BLEND: begin
                cmd.blend = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == bsb_pkg::CH_LAST) begin
                    state_next = S_WR;
                end
            end
            S_WR: begin
                cmd.wr_stamp = 1'b1;
                if (stat.off_last) begin
                    state_next = S_DONE;
                end else begin
                    cmd.next_off = 1'b1;
                    state_next   = S_TEST;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### rtl/brush_stamp_blend.sv
// Canvas memory with a round, force-scaled brush stamp.
// The input channel carries one action per transfer: write a pixel, read a pixel,
// or stamp the brush around a center pixel. Every accepted action returns exactly
// one transfer on the output channel: the read color and an off-canvas flag.
// A write runs the execute and done states; a read adds a capture state between.
// A stamp visits 2500 offsets; an offset outside the brush or the canvas is only
// tested, while an offset that is painted also runs the bit-serial square root
// (22 steps) and divider (17 steps) that compute its falloff.
// One action is worked on at a time; the next is taken as soon as the result
// sits in the output register, even if the receiver has not yet taken it.
// When the receiver stalls, the finished result is held and a second finished
// result waits inside the block until the register frees.
// Reset clears the control logic and restores the register defaults; canvas
// contents are undefined until written. Configuration writes are taken any
// cycle but should only be issued while the block is idle.
module brush_stamp_blend (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // column, row, red, green, blue, force_req, time_step
    input  logic [71:0] s_tdata,
    // action
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_red, read_green, read_blue
    output logic [23:0] m_tdata,
    // status
    output logic        m_tuser
);

    bsb_pkg::cmd_t  cmd;
    bsb_pkg::stat_t stat;

    bsb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bsb_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_action    (s_tuser),
        .in_column    (s_tdata[7:0]),
        .in_row       (s_tdata[15:8]),
        .in_red       (s_tdata[23:16]),
        .in_green     (s_tdata[31:24]),
        .in_blue      (s_tdata[39:32]),
        .in_force_req (s_tdata[55:40]),
        .in_time_step (s_tdata[71:56]),
        .cmd          (cmd),
        .stat         (stat),
        .out_rgb      (m_tdata),
        .out_status   (m_tuser)
    );

endmodule
